// ----- design/quaternion_alu_defines.svh -----
// Assertion macros shared by the quaternion ALU RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef QUATERNION_ALU_DEFINES_SVH
`define QUATERNION_ALU_DEFINES_SVH

// Clocked check, switched off while reset is held
`define QALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds across reset
`define QALU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- design/qalu_pkg.sv -----
// Package for the quaternion ALU: widths, request codes and stage structs.
// No dependencies.
`timescale 1ns / 1ps

package qalu_pkg;

  // Component format: signed Q2.14 in 16 bits
  localparam int CompW = 16;
  localparam int FracW = 14;
  localparam int ProdW = 2 * CompW;
  // Four products summed with sign, plus headroom
  localparam int SumW  = ProdW + 3;
  localparam int NormW = 33;
  localparam int Lanes = 4;

  typedef enum logic [2:0] {
    ReqProduct = 3'd0,
    ReqVector  = 3'd1,
    ReqScale   = 3'd2,
    ReqConj    = 3'd3,
    ReqNorm    = 3'd4,
    ReqEqual   = 3'd5
  } req_e;

  typedef logic [CompW-1:0] comp_t;
  typedef logic signed [SumW-1:0] sum_t;

  // Operand pairs of one dot-product lane; neg subtracts that product
  typedef struct packed {
    logic [3:0][CompW-1:0] a;
    logic [3:0][CompW-1:0] b;
    logic [3:0]            neg;
  } dot_ops_t;

  // Request info that travels alongside the arithmetic
  typedef struct packed {
    req_e op;
    logic eq;
  } side_t;

endpackage

// ----- design/qalu_operand.sv -----
// Stage one of the quaternion ALU: routes components into four dot-product lanes.
// Depends on qalu_pkg.
`timescale 1ns / 1ps

module qalu_operand (
  input  logic                               clk_i,
  input  logic [2:0]                         req_type_i,
  input  logic [3:0][qalu_pkg::CompW-1:0]    left_i,
  input  logic [3:0][qalu_pkg::CompW-1:0]    right_i,
  input  logic [qalu_pkg::CompW-1:0]         scale_i,
  output qalu_pkg::dot_ops_t                 lanes_o [qalu_pkg::Lanes],
  output qalu_pkg::side_t                    side_o
);
  import qalu_pkg::*;

  // Plus and minus one in Q format, used to build the conjugate
  localparam comp_t QOne      = CompW'(2 ** FracW);
  localparam comp_t QMinusOne = CompW'(~QOne + 1'b1);
  localparam comp_t Zero      = '0;

  dot_ops_t lanes_d [Lanes];
  dot_ops_t lanes_q [Lanes];
  side_t    side_d;
  side_t    side_q;
  req_e     op;
  comp_t    bw;

  function automatic dot_ops_t mk(input comp_t a0, input comp_t b0, input comp_t a1,
                                  input comp_t b1, input comp_t a2, input comp_t b2,
                                  input comp_t a3, input comp_t b3, input logic [3:0] neg);
    dot_ops_t r;
    r.a   = {a3, a2, a1, a0};
    r.b   = {b3, b2, b1, b0};
    r.neg = neg;
    return r;
  endfunction

  assign op = req_e'(req_type_i);

  // Operand routing per request
  always_comb begin
    lanes_d = '{default: '0};
    bw      = (op == ReqVector) ? Zero : right_i[3];
    case (op)
      ReqProduct, ReqVector: begin
        lanes_d[0] = mk(left_i[0], bw, left_i[3], right_i[0],
                        left_i[1], right_i[2], left_i[2], right_i[1], 4'b1000);
        lanes_d[1] = mk(left_i[1], bw, left_i[3], right_i[1],
                        left_i[2], right_i[0], left_i[0], right_i[2], 4'b1000);
        lanes_d[2] = mk(left_i[2], bw, left_i[3], right_i[2],
                        left_i[0], right_i[1], left_i[1], right_i[0], 4'b1000);
        lanes_d[3] = mk(left_i[3], bw, left_i[0], right_i[0],
                        left_i[1], right_i[1], left_i[2], right_i[2], 4'b1110);
      end
      ReqScale: begin
        for (int i = 0; i < Lanes; i++) begin
          lanes_d[i] = mk(left_i[i], scale_i, Zero, Zero, Zero, Zero, Zero, Zero, 4'b0000);
        end
      end
      ReqConj: begin
        // Multiply by minus one so negation shares the saturating path
        for (int i = 0; i < Lanes - 1; i++) begin
          lanes_d[i] = mk(left_i[i], QMinusOne, Zero, Zero, Zero, Zero, Zero, Zero, 4'b0000);
        end
        lanes_d[3] = mk(left_i[3], QOne, Zero, Zero, Zero, Zero, Zero, Zero, 4'b0000);
      end
      ReqNorm: begin
        // Sum of squares runs in the w lane
        lanes_d[3] = mk(left_i[0], left_i[0], left_i[1], left_i[1],
                        left_i[2], left_i[2], left_i[3], left_i[3], 4'b0000);
      end
      default: begin
        lanes_d = '{default: '0};
      end
    endcase
  end

  // Equality is settled here and rides along
  always_comb begin
    side_d.op = op;
    side_d.eq = (op == ReqEqual) && (left_i == right_i);
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    side_q  <= side_d;
  end

  assign lanes_o = lanes_q;
  assign side_o  = side_q;

endmodule

// ----- design/qalu_dot4.sv -----
// One lane of four signed products and their signed sum, two register stages.
// Depends on qalu_pkg.
`timescale 1ns / 1ps

module qalu_dot4 (
  input  logic               clk_i,
  input  qalu_pkg::dot_ops_t ops_i,
  output qalu_pkg::sum_t     sum_o
);
  import qalu_pkg::*;

  logic signed [ProdW-1:0] prod_d [4];
  logic signed [ProdW-1:0] prod_q [4];
  logic [3:0]              neg_q;
  sum_t                    sum_d;
  sum_t                    sum_q;

  // Multiplier stage
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_d[k] = $signed(ops_i.a[k]) * $signed(ops_i.b[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= ops_i.neg;
  end

  // Exact signed sum of the four products
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 4; k++) begin
      if (neg_q[k]) begin
        sum_d = sum_d - SumW'(prod_q[k]);
      end else begin
        sum_d = sum_d + SumW'(prod_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

// ----- design/qalu_result.sv -----
// Final stage: fraction shift, saturation, field selection and output registers.
// Depends on qalu_pkg.
`timescale 1ns / 1ps

module qalu_result (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  qalu_pkg::side_t                 side_i,
  input  qalu_pkg::sum_t                  sum_i [qalu_pkg::Lanes],
  output logic                            done_o,
  output logic [3:0][qalu_pkg::CompW-1:0] comp_o,
  output logic [qalu_pkg::NormW-1:0]      norm_o,
  output logic                            eq_o,
  output logic                            ovf_o
);
  import qalu_pkg::*;

  localparam int ShW = SumW - FracW;
  localparam logic signed [ShW-1:0] ShMax = ShW'(2 ** (CompW - 1) - 1);
  localparam logic signed [ShW-1:0] ShMin = ~ShMax;
  localparam comp_t CompMax = {1'b0, {(CompW - 1){1'b1}}};
  localparam comp_t CompMin = {1'b1, {(CompW - 1){1'b0}}};

  logic [3:0][CompW-1:0] sat_val;
  logic [3:0]            sat_ovf;
  logic [3:0][CompW-1:0] comp_d, comp_q;
  logic [NormW-1:0]      norm_d, norm_q;
  logic                  eq_d, eq_q, ovf_d, ovf_q;
  logic                  done_q;

  // Floor shift, then clamp into the component range
  always_comb begin
    logic signed [ShW-1:0] sh;
    for (int i = 0; i < Lanes; i++) begin
      sh = ShW'(sum_i[i] >>> FracW);
      if (sh > ShMax) begin
        sat_val[i] = CompMax;
        sat_ovf[i] = 1'b1;
      end else if (sh < ShMin) begin
        sat_val[i] = CompMin;
        sat_ovf[i] = 1'b1;
      end else begin
        sat_val[i] = sh[CompW-1:0];
        sat_ovf[i] = 1'b0;
      end
    end
  end

  // Pick the fields that the request fills; the rest read zero
  always_comb begin
    comp_d = '0;
    norm_d = '0;
    eq_d   = 1'b0;
    ovf_d  = 1'b0;
    case (side_i.op)
      ReqProduct, ReqVector, ReqScale, ReqConj: begin
        comp_d = sat_val;
        ovf_d  = |sat_ovf;
      end
      ReqNorm: begin
        norm_d = sum_i[3][NormW-1:0];
      end
      ReqEqual: begin
        eq_d = side_i.eq;
      end
      default: begin
        comp_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    comp_q <= comp_d;
    norm_q <= norm_d;
    eq_q   <= eq_d;
    ovf_q  <= ovf_d;
  end

  assign done_o = done_q;
  assign comp_o = comp_q;
  assign norm_o = norm_q;
  assign eq_o   = eq_q;
  assign ovf_o  = ovf_q;

endmodule

// ----- design/quaternion_alu.sv -----
// Top level of the fixed-point quaternion ALU, four register stages.
// Depends on qalu_pkg, qalu_operand, qalu_dot4, qalu_result, quaternion_alu_defines.svh.
//
// Usage:
//   A request is taken at a rising edge with start_i high and busy_o low. busy_o is
//   always low: the pipeline takes one request every cycle.
//   Each request gives one result, shown for a single cycle with done_o high.
//   done_o rises with the result, which passes operand routing, multipliers,
//   four-term adders, saturation and the output register in that order.
//   Results leave in request order; throughput is one per clock, set by the
//   sixteen 16x16 multipliers working in parallel across four lanes.
//   The receiver cannot stall; a result must be taken in its done_o cycle.
//   req_type_i: product, times vector, scale, conjugate, length squared,
//   equality; unused codes give an all-zero result.
//   Components are signed Q2.14; products are floor-shifted by 14 and
//   saturated, with overflow_o set when any component clipped.
//   Reset (rst_ni low, asynchronous) clears the valid bits; requests in
//   flight are dropped and no result appears for them.
`timescale 1ns / 1ps
`include "quaternion_alu_defines.svh"

module quaternion_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [2:0]                 req_type_i,
  input  logic signed [15:0]         left_x_i,
  input  logic signed [15:0]         left_y_i,
  input  logic signed [15:0]         left_z_i,
  input  logic signed [15:0]         left_w_i,
  input  logic signed [15:0]         right_x_i,
  input  logic signed [15:0]         right_y_i,
  input  logic signed [15:0]         right_z_i,
  input  logic signed [15:0]         right_w_i,
  input  logic signed [15:0]         scale_factor_i,
  output logic                       done_o,
  output logic signed [15:0]         out_x_o,
  output logic signed [15:0]         out_y_o,
  output logic signed [15:0]         out_z_o,
  output logic signed [15:0]         out_w_o,
  output logic [32:0]                norm_squared_o,
  output logic                       is_equal_o,
  output logic                       overflow_o
);
  import qalu_pkg::*;

  logic [3:0][CompW-1:0] left;
  logic [3:0][CompW-1:0] right;
  logic [3:0][CompW-1:0] comp;
  dot_ops_t              lanes [Lanes];
  sum_t                  sums [Lanes];
  side_t                 side_s1;
  side_t                 side_q [2];
  logic [2:0]            valid_q;

  // Never holds off a request
  assign busy_o = 1'b0;

  assign left  = {left_w_i, left_z_i, left_y_i, left_x_i};
  assign right = {right_w_i, right_z_i, right_y_i, right_x_i};

  // Valid bits for the first three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], start_i && !busy_o};
    end
  end

  // Request info delayed alongside the two lane stages
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_s1;
    side_q[1] <= side_q[0];
  end

  qalu_operand u_operand (
    .clk_i      (clk_i),
    .req_type_i (req_type_i),
    .left_i     (left),
    .right_i    (right),
    .scale_i    (scale_factor_i),
    .lanes_o    (lanes),
    .side_o     (side_s1)
  );

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    qalu_dot4 u_dot4 (
      .clk_i (clk_i),
      .ops_i (lanes[g]),
      .sum_o (sums[g])
    );
  end

  qalu_result u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q[2]),
    .side_i  (side_q[1]),
    .sum_i   (sums),
    .done_o  (done_o),
    .comp_o  (comp),
    .norm_o  (norm_squared_o),
    .eq_o    (is_equal_o),
    .ovf_o   (overflow_o)
  );

  assign out_x_o = comp[0];
  assign out_y_o = comp[1];
  assign out_z_o = comp[2];
  assign out_w_o = comp[3];

  // Checks
  `QALU_ASSERT(a_latency, (start_i && !busy_o |-> ##4 done_o), "request lost in pipeline")
  `QALU_ASSERT(a_no_spurious, (done_o |-> $past(start_i && !busy_o, 4)), "result without request")
  `QALU_ASSERT(a_field_excl, (!(is_equal_o && (overflow_o || norm_squared_o != '0))), "fields mixed")
  `QALU_ASSERT_ALWAYS(a_reset_quiet, (!rst_ni |=> !done_o), "result during reset")

endmodule
